// ===== src/mpfb_pkg.sv =====
// Shared types and constants for the page-organized monochrome frame buffer.
// Used by the sweep engine, the clip unit, the top level and the checker.
// Depends on nothing.
package mpfb_pkg;

   // Default screen size.
   localparam int DEF_SCREEN_WIDTH = 128;
   localparam int DEF_SCREEN_HEIGHT = 64;

   // Field and counter widths, sized for the largest supported screen.
   localparam int ROW_BITS = 3;
   localparam int ROWS_PER_PAGE = 1 << ROW_BITS;
   localparam int COL_BITS = 8;
   localparam int PAGE_BITS = 5;
   localparam int POS_BITS = 10;
   localparam int SIZE_BITS = 8;
   localparam int INDEX_BITS = 10;
   localparam int DATA_BITS = 8;
   localparam int CMD_BITS = 2;
   localparam int REQ_TDATA_BITS = 48;

   // Command codes carried on req_tuser.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_FILL  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // One captured request beat.
   typedef struct packed {
      cmd_type                      cmd;
      logic signed [POS_BITS-1:0]   x_pos;
      logic signed [POS_BITS-1:0]   y_pos;
      logic [SIZE_BITS-1:0]         rect_width;
      logic [SIZE_BITS-1:0]         rect_height;
      logic                         pixel_on;
      logic [INDEX_BITS-1:0]        byte_index;
   } req_type;

   // Drawing area clipped to the screen, in columns, pages and rows.
   typedef struct packed {
      logic                  empty;
      logic [COL_BITS-1:0]   col0;
      logic [COL_BITS-1:0]   col1;
      logic [PAGE_BITS-1:0]  page0;
      logic [PAGE_BITS-1:0]  page1;
      logic [ROW_BITS-1:0]   row_lo;
      logic [ROW_BITS-1:0]   row_hi;
   } clip_type;

   // Control from the top level to the sweep engine.
   typedef struct packed {
      logic start;
      logic slot_free;
   } seq_ctl_type;

   // Status from the sweep engine to the top level.
   typedef struct packed {
      logic                  idle;
      logic                  done;
      logic [DATA_BITS-1:0]  read_data;
   } seq_stat_type;

endpackage

// ===== src/mpfb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
module mpfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mpfb_clip.sv =====
// Clips a pixel or rectangle request to the screen and converts it to
// column, page and row bounds. Depends on mpfb_pkg.
module mpfb_clip #(
   parameter int SCREEN_WIDTH = mpfb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mpfb_pkg::DEF_SCREEN_HEIGHT
) (
   input  mpfb_pkg::cmd_type                       cmd,
   input  logic signed [mpfb_pkg::POS_BITS-1:0]    x_pos,
   input  logic signed [mpfb_pkg::POS_BITS-1:0]    y_pos,
   input  logic [mpfb_pkg::SIZE_BITS-1:0]          rect_width,
   input  logic [mpfb_pkg::SIZE_BITS-1:0]          rect_height,
   output mpfb_pkg::clip_type                      clip
);

   localparam logic signed [11:0] WIDTH_S = 12'(SCREEN_WIDTH);
   localparam logic signed [11:0] HEIGHT_S = 12'(SCREEN_HEIGHT);

   logic signed [11:0] xs, ys, ws, hs;
   logic signed [11:0] x1, y1, x0c, y0c, x1c, y1c, xl, yl;

   // A single pixel is a one by one rectangle.
   assign xs = 12'(x_pos);
   assign ys = 12'(y_pos);
   assign ws = (cmd == mpfb_pkg::CMD_PIXEL) ? 12'sd1 : $signed({4'b0000, rect_width});
   assign hs = (cmd == mpfb_pkg::CMD_PIXEL) ? 12'sd1 : $signed({4'b0000, rect_height});

   // Intersect the half-open span with the screen.
   assign x1 = xs + ws;
   assign y1 = ys + hs;
   assign x0c = (xs < 12'sd0) ? 12'sd0 : xs;
   assign y0c = (ys < 12'sd0) ? 12'sd0 : ys;
   assign x1c = (x1 > WIDTH_S) ? WIDTH_S : x1;
   assign y1c = (y1 > HEIGHT_S) ? HEIGHT_S : y1;
   assign xl = x1c - 12'sd1;
   assign yl = y1c - 12'sd1;

   // Inclusive bounds; they only matter when the area is not empty.
   always_comb begin
      clip.empty  = (x0c >= x1c) || (y0c >= y1c);
      clip.col0   = x0c[7:0];
      clip.col1   = xl[7:0];
      clip.page0  = y0c[7:3];
      clip.page1  = yl[7:3];
      clip.row_lo = y0c[2:0];
      clip.row_hi = yl[2:0];
   end

endmodule

// ===== src/mpfb_sweep.sv =====
// Sweep engine: walks the store byte by byte for clears and fills, does the
// read-modify-write of each pixel or fill byte and serves byte reads. Depends on mpfb_pkg.
module mpfb_sweep #(
   parameter int SCREEN_WIDTH = mpfb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mpfb_pkg::DEF_SCREEN_HEIGHT,
   parameter int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mpfb_pkg::seq_ctl_type                  ctl,
   input  mpfb_pkg::cmd_type                      cmd,
   input  logic                                   pixel_on,
   input  logic [mpfb_pkg::INDEX_BITS-1:0]        byte_index,
   input  mpfb_pkg::clip_type                     clip,
   output mpfb_pkg::seq_stat_type                 stat,
   output logic                                   wr_en,
   output logic [$clog2(STORE_BYTES)-1:0]         wr_addr,
   output logic [mpfb_pkg::DATA_BITS-1:0]         wr_data,
   output logic                                   rd_en,
   output logic [$clog2(STORE_BYTES)-1:0]         rd_addr,
   input  logic [mpfb_pkg::DATA_BITS-1:0]         rd_data
);

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int PAGE_COUNT = (SCREEN_HEIGHT + mpfb_pkg::ROWS_PER_PAGE - 1)
                               / mpfb_pkg::ROWS_PER_PAGE;
   localparam logic [mpfb_pkg::COL_BITS-1:0] LAST_COL = mpfb_pkg::COL_BITS'(SCREEN_WIDTH - 1);
   localparam logic [mpfb_pkg::PAGE_BITS-1:0] LAST_PAGE = mpfb_pkg::PAGE_BITS'(PAGE_COUNT - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_READ,
      ST_FINISH
   } state_type;

   // Bits of one page byte that lie between rows lo and hi, inclusive.
   function automatic logic [7:0] row_mask(input logic [2:0] lo, input logic [2:0] hi);
      row_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
   endfunction

   state_type                         state_ff, state_in;
   logic                              init_ff, init_in;
   logic                              clr_ff, clr_in;
   logic                              on_ff, on_in;
   logic [mpfb_pkg::COL_BITS-1:0]     col_ff, col_in, col0_ff, col0_in, col1_ff, col1_in;
   logic [mpfb_pkg::PAGE_BITS-1:0]    page_ff, page_in, page0_ff, page0_in, page1_ff, page1_in;
   logic [mpfb_pkg::ROW_BITS-1:0]     rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [ADDR_W-1:0]                 base_ff, base_in;
   logic                              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]                 s1_addr_ff, s1_addr_in;
   logic [7:0]                        s1_mask_ff, s1_mask_in;
   logic [mpfb_pkg::DATA_BITS-1:0]    data_ff, data_in;
   logic                              done;
   logic [ADDR_W-1:0]                 addr;
   logic [7:0]                        mask;
   logic                              last_col, last_page, index_ok;

   assign addr = base_ff + ADDR_W'(col_ff);
   assign last_col = (col_ff == col1_ff);
   assign last_page = (page_ff == page1_ff);
   assign mask = row_mask((page_ff == page0_ff) ? rlo_ff : 3'd0,
                          (page_ff == page1_ff) ? rhi_ff : 3'd7);
   assign index_ok = (32'(byte_index) < 32'(STORE_BYTES));

   // Next-state logic and memory port control.
   always_comb begin
      state_in    = state_ff;
      init_in     = init_ff;
      clr_in      = clr_ff;
      on_in       = on_ff;
      col_in      = col_ff;
      col0_in     = col0_ff;
      col1_in     = col1_ff;
      page_in     = page_ff;
      page0_in    = page0_ff;
      page1_in    = page1_ff;
      rlo_in      = rlo_ff;
      rhi_in      = rhi_ff;
      base_in     = base_ff;
      s1_valid_in = 1'b0;
      s1_addr_in  = s1_addr_ff;
      s1_mask_in  = s1_mask_ff;
      data_in     = data_ff;
      done        = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = addr;

      // Second half of a read-modify-write: merge the mask into the byte read.
      wr_en   = s1_valid_ff;
      wr_addr = s1_addr_ff;
      wr_data = on_ff ? (rd_data | s1_mask_ff) : (rd_data & ~s1_mask_ff);

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               data_in = '0;
               case (cmd)
                  mpfb_pkg::CMD_CLEAR: begin
                     clr_in   = 1'b1;
                     col_in   = '0;
                     col0_in  = '0;
                     col1_in  = LAST_COL;
                     page_in  = '0;
                     page0_in = '0;
                     page1_in = LAST_PAGE;
                     base_in  = '0;
                     state_in = ST_SWEEP;
                  end
                  mpfb_pkg::CMD_PIXEL, mpfb_pkg::CMD_FILL: begin
                     if (clip.empty) begin
                        state_in = ST_FINISH;
                     end else begin
                        clr_in   = 1'b0;
                        on_in    = pixel_on;
                        col_in   = clip.col0;
                        col0_in  = clip.col0;
                        col1_in  = clip.col1;
                        page_in  = clip.page0;
                        page0_in = clip.page0;
                        page1_in = clip.page1;
                        rlo_in   = clip.row_lo;
                        rhi_in   = clip.row_hi;
                        base_in  = ADDR_W'(clip.page0) * ROW_STRIDE;
                        state_in = ST_SWEEP;
                     end
                  end
                  mpfb_pkg::CMD_READ: begin
                     if (index_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(byte_index);
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // Clears write zeros directly; pixels and fills read now and write next cycle.
            if (clr_ff) begin
               wr_en   = 1'b1;
               wr_addr = addr;
               wr_data = '0;
            end else begin
               rd_en       = 1'b1;
               s1_valid_in = 1'b1;
               s1_addr_in  = addr;
               s1_mask_in  = mask;
            end
            if (last_col) begin
               col_in  = col0_ff;
               page_in = page_ff + 1'b1;
               base_in = base_ff + ROW_STRIDE;
               if (last_page) begin
                  init_in = 1'b0;
                  if (!clr_ff) begin
                     state_in = ST_DRAIN;
                  end else if (init_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_READ: begin
            data_in  = rd_data;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (ctl.slot_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered values; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         init_ff     <= 1'b1;
         clr_ff      <= 1'b1;
         col_ff      <= '0;
         col0_ff     <= '0;
         col1_ff     <= LAST_COL;
         page_ff     <= '0;
         page0_ff    <= '0;
         page1_ff    <= LAST_PAGE;
         base_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_ff     <= init_in;
         clr_ff      <= clr_in;
         col_ff      <= col_in;
         col0_ff     <= col0_in;
         col1_ff     <= col1_in;
         page_ff     <= page_in;
         page0_ff    <= page0_in;
         page1_ff    <= page1_in;
         base_ff     <= base_in;
         s1_valid_ff <= s1_valid_in;
      end
      on_ff      <= on_in;
      rlo_ff     <= rlo_in;
      rhi_ff     <= rhi_in;
      s1_addr_ff <= s1_addr_in;
      s1_mask_ff <= s1_mask_in;
      data_ff    <= data_in;
   end

   always_comb begin
      stat.idle      = (state_ff == ST_IDLE);
      stat.done      = done;
      stat.read_data = data_ff;
   end

endmodule

// ===== src/mono_page_framebuffer_draw.sv =====
// Monochrome page-organized frame buffer with drawing commands (top level).
// Depends on mpfb_pkg, mpfb_ram, mpfb_clip and mpfb_sweep.
//
// The frame store holds one bit per pixel in pages of eight rows: byte
// page * SCREEN_WIDTH + column holds one column of a page, bit n being row n.
// One command is taken at a time and each gives one response beat. A fill
// sweeps its clipped columns and pages, one store byte per cycle through the
// single read-modify-write path of the frame store, and a clear writes the
// whole store, one byte written per cycle. A pixel or fill that lands fully
// off screen writes nothing. The next command can be taken as soon as the
// response is registered. After reset the store is cleared in a pass over
// all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes (1024 at the default
// size) during which req_tready stays low.
module mono_page_framebuffer_draw #(
   parameter int SCREEN_WIDTH = mpfb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mpfb_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // x_pos[9:0], y_pos[19:10], rect_width[27:20], rect_height[35:28],
   // pixel_on[36], byte_index[46:37], zero pad[47]
   input  logic [mpfb_pkg::REQ_TDATA_BITS-1:0]       req_tdata,
   // cmd[1:0]
   input  logic [mpfb_pkg::CMD_BITS-1:0]             req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // read_data[7:0]
   output logic [mpfb_pkg::DATA_BITS-1:0]            rsp_tdata
);

   localparam int PAGE_COUNT = (SCREEN_HEIGHT + mpfb_pkg::ROWS_PER_PAGE - 1)
                               / mpfb_pkg::ROWS_PER_PAGE;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W = $clog2(STORE_BYTES);

   mpfb_pkg::req_type        req_ff, req_in;
   logic                     busy_ff, busy_in;
   logic                     start_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [mpfb_pkg::DATA_BITS-1:0] rsp_data_ff;
   logic                     accept;
   mpfb_pkg::seq_ctl_type    ctl;
   mpfb_pkg::seq_stat_type   stat;
   mpfb_pkg::clip_type       clip;
   logic                     wr_en, rd_en;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic [mpfb_pkg::DATA_BITS-1:0] wr_data, rd_data;

   assign req_tready = !busy_ff && stat.idle;
   assign accept = req_tvalid && req_tready;

   // Unpack the request beat.
   always_comb begin
      req_in.cmd         = mpfb_pkg::cmd_type'(req_tuser);
      req_in.x_pos       = req_tdata[9:0];
      req_in.y_pos       = req_tdata[19:10];
      req_in.rect_width  = req_tdata[27:20];
      req_in.rect_height = req_tdata[35:28];
      req_in.pixel_on    = req_tdata[36];
      req_in.byte_index  = req_tdata[46:37];
   end

   // Busy from accept until the response is registered; the response
   // register frees the engine as soon as it takes the result.
   always_comb begin
      busy_in = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (stat.done) begin
         busy_in = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= accept;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         req_ff <= req_in;
      end
      if (stat.done) begin
         rsp_data_ff <= stat.read_data;
      end
   end

   always_comb begin
      ctl.start     = start_ff;
      ctl.slot_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   mpfb_clip #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_clip (
      .cmd         (req_ff.cmd),
      .x_pos       (req_ff.x_pos),
      .y_pos       (req_ff.y_pos),
      .rect_width  (req_ff.rect_width),
      .rect_height (req_ff.rect_height),
      .clip        (clip)
   );

   mpfb_sweep #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .STORE_BYTES   (STORE_BYTES)
   ) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cmd        (req_ff.cmd),
      .pixel_on   (req_ff.pixel_on),
      .byte_index (req_ff.byte_index),
      .clip       (clip),
      .stat       (stat),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   mpfb_ram #(
      .WIDTH (mpfb_pkg::DATA_BITS),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== src/mpfb_checker.sv =====
// Port-level checks for the frame buffer top level, bound to every instance.
// Depends on mono_page_framebuffer_draw and mpfb_pkg.
module mpfb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mpfb_pkg::DATA_BITS-1:0]   rsp_tdata
);

   // A stalled response beat stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // The clearing pass after reset holds off requests.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request taken during the clearing pass");

   // Only one command is in flight at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in flight");

   // No response can appear in the cycle right after a command is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared too early after a command");

endmodule

bind mono_page_framebuffer_draw mpfb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/mono_page_framebuffer_draw_test.sv =====
// Self-checking bench for the page-organized monochrome frame buffer.
// It keeps its own frame store, predicts every response byte, and drives
// directed, random and back-pressure command streams. Depends on mpfb_pkg.
module mono_page_framebuffer_draw_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCR_W = mpfb_pkg::DEF_SCREEN_WIDTH;
   localparam int SCR_H = mpfb_pkg::DEF_SCREEN_HEIGHT;
   localparam int PAGES = (SCR_H + mpfb_pkg::ROWS_PER_PAGE - 1) / mpfb_pkg::ROWS_PER_PAGE;
   localparam int STORE_BYTES = SCR_W * PAGES;
   // Longest run of cycles without any beat on either side.
   localparam int QUIET_LIMIT = 20000;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   // x_pos[9:0], y_pos[19:10], rect_width[27:20], rect_height[35:28],
   // pixel_on[36], byte_index[46:37], zero pad[47]
   logic [mpfb_pkg::REQ_TDATA_BITS-1:0]  req_tdata = '0;
   // cmd[1:0]
   logic [mpfb_pkg::CMD_BITS-1:0]        req_tuser = mpfb_pkg::CMD_CLEAR;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // read_data[7:0]
   logic [mpfb_pkg::DATA_BITS-1:0]       rsp_tdata;

   // Shadow copy of the frame store and the queue of predicted read bytes.
   logic [mpfb_pkg::DATA_BITS-1:0]       shadow_store [STORE_BYTES];
   logic [mpfb_pkg::DATA_BITS-1:0]       expected_bytes [$];
   logic [mpfb_pkg::DATA_BITS-1:0]       want_byte;
   int                                   error_count = 0;
   int                                   quiet_cycles = 0;

   // Idle control for both sides and the long receiver hold-off.
   bit                                   req_idle_on = 1'b1;
   bit                                   rsp_idle_on = 1'b1;
   bit                                   hold_toggle = 1'b0;
   bit                                   hold_seen = 1'b0;
   int                                   hold_len = 0;
   int                                   hold_left = 0;

   mono_page_framebuffer_draw i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Sets or clears one pixel of the shadow store; off-screen pixels are skipped.
   function automatic void shadow_pixel(int x, int y, logic on);
      int addr;
      if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) begin
         return;
      end
      addr = (y / mpfb_pkg::ROWS_PER_PAGE) * SCR_W + x;
      shadow_store[addr][y % mpfb_pkg::ROWS_PER_PAGE] = on;
   endfunction

   // Applies one command to the shadow store and returns the response byte.
   function automatic logic [mpfb_pkg::DATA_BITS-1:0] apply_draw_cmd(mpfb_pkg::req_type r);
      int x;
      int y;
      int x0;
      int y0;
      int x1;
      int y1;
      logic [mpfb_pkg::DATA_BITS-1:0] rd;
      rd = '0;
      x = int'($signed(r.x_pos));
      y = int'($signed(r.y_pos));
      case (r.cmd)
         mpfb_pkg::CMD_CLEAR: begin
            foreach (shadow_store[i]) shadow_store[i] = '0;
         end
         mpfb_pkg::CMD_PIXEL: begin
            shadow_pixel(x, y, r.pixel_on);
         end
         mpfb_pkg::CMD_FILL: begin
            // Only the part of the rectangle on screen is touched.
            x0 = (x < 0) ? 0 : x;
            y0 = (y < 0) ? 0 : y;
            x1 = x + int'(r.rect_width);
            y1 = y + int'(r.rect_height);
            if (x1 > SCR_W) x1 = SCR_W;
            if (y1 > SCR_H) y1 = SCR_H;
            for (int cy = y0; cy < y1; cy++) begin
               for (int cx = x0; cx < x1; cx++) begin
                  shadow_pixel(cx, cy, r.pixel_on);
               end
            end
         end
         default: begin
            if (int'(r.byte_index) < STORE_BYTES) begin
               rd = shadow_store[r.byte_index];
            end
         end
      endcase
      return rd;
   endfunction

   function automatic mpfb_pkg::req_type make_cmd(mpfb_pkg::cmd_type c, int x, int y, int w,
                                                  int h, logic on, int idx);
      mpfb_pkg::req_type r;
      r.cmd = c;
      r.x_pos = x[mpfb_pkg::POS_BITS-1:0];
      r.y_pos = y[mpfb_pkg::POS_BITS-1:0];
      r.rect_width = w[mpfb_pkg::SIZE_BITS-1:0];
      r.rect_height = h[mpfb_pkg::SIZE_BITS-1:0];
      r.pixel_on = on;
      r.byte_index = idx[mpfb_pkg::INDEX_BITS-1:0];
      return r;
   endfunction

   // Random command: mostly near-screen draws and reads of live addresses,
   // with some fully random fields and a rare clear.
   function automatic mpfb_pkg::req_type random_cmd();
      mpfb_pkg::req_type r;
      int pick;
      int xs;
      int ys;
      r.x_pos = mpfb_pkg::POS_BITS'($urandom);
      r.y_pos = mpfb_pkg::POS_BITS'($urandom);
      r.rect_width = mpfb_pkg::SIZE_BITS'($urandom);
      r.rect_height = mpfb_pkg::SIZE_BITS'($urandom);
      r.pixel_on = ($urandom_range(99) < 70);
      r.byte_index = mpfb_pkg::INDEX_BITS'($urandom);
      pick = $urandom_range(199);
      if (pick < 3) r.cmd = mpfb_pkg::CMD_CLEAR;
      else if (pick < 70) r.cmd = mpfb_pkg::CMD_PIXEL;
      else if (pick < 120) r.cmd = mpfb_pkg::CMD_FILL;
      else r.cmd = mpfb_pkg::CMD_READ;
      if ($urandom_range(9) != 0) begin
         r.x_pos = mpfb_pkg::POS_BITS'($urandom_range(SCR_W + 15) - 8);
         r.y_pos = mpfb_pkg::POS_BITS'($urandom_range(SCR_H + 15) - 8);
      end
      if (r.cmd == mpfb_pkg::CMD_FILL && $urandom_range(19) != 0) begin
         r.rect_width = mpfb_pkg::SIZE_BITS'($urandom_range(40));
         r.rect_height = mpfb_pkg::SIZE_BITS'($urandom_range(24));
      end
      if (r.cmd == mpfb_pkg::CMD_READ && $urandom_range(7) != 0) begin
         xs = $urandom_range(SCR_W - 1);
         ys = $urandom_range(SCR_H - 1);
         r.byte_index = mpfb_pkg::INDEX_BITS'((ys / mpfb_pkg::ROWS_PER_PAGE) * SCR_W + xs);
      end
      return r;
   endfunction

   // Offers one command beat and records its predicted response once taken.
   task automatic offer_cmd(input mpfb_pkg::req_type r);
      while (req_idle_on && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= {1'b0, r.byte_index, r.pixel_on, r.rect_height, r.rect_width,
                    r.y_pos, r.x_pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_bytes.push_back(apply_draw_cmd(r));
   endtask

   task automatic wait_drained();
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // Field extremes, every command, off-screen pixels, clipped and empty fills.
   task automatic test_directed();
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 1023));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, -1, 5, 0, 0, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, SCR_W, 5, 0, 0, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, 5, SCR_H, 0, 0, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, -512, -512, 255, 255, 1'b1, 1023));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, 511, 511, 0, 0, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
      offer_cmd(make_cmd(mpfb_pkg::CMD_FILL, -5, -3, 10, 12, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_FILL, 10, 10, 0, 255, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_FILL, 10, 10, 255, 0, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_FILL, SCR_W - 8, SCR_H - 4, 255, 255, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, SCR_W + 3));
      offer_cmd(make_cmd(mpfb_pkg::CMD_FILL, 0, 0, 3, 3, 1'b0, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_FILL, -512, -512, 255, 255, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_FILL, 0, 0, 255, 255, 1'b1, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 517));
      offer_cmd(make_cmd(mpfb_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 517));
      offer_cmd(make_cmd(mpfb_pkg::CMD_PIXEL, 0, 0, 0, 0, 1'b0, 0));
      offer_cmd(make_cmd(mpfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 0));
   endtask

   // Random commands with both sides idling at random.
   task automatic test_random_idling(input int count);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (count) offer_cmd(random_cmd());
   endtask

   // Random commands with no idling on either side.
   task automatic test_random_streaming(input int count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (count) offer_cmd(random_cmd());
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while commands keep coming.
   task automatic test_backpressure(input int count);
      req_idle_on = 1'b0;
      hold_len = 400;
      hold_toggle = ~hold_toggle;
      repeat (count) offer_cmd(random_cmd());
      req_idle_on = 1'b1;
   endtask

   // Stimulus sequence and final verdict; the shadow store starts cleared.
   initial begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_idling(300);
      test_random_streaming(200);
      test_backpressure(30);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Response side: accepts beats, compares them, and drives rsp_tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response beat, actual read_data %02h",
                        $time, rsp_tdata);
            end else begin
               want_byte = expected_bytes.pop_front();
               if (rsp_tdata !== want_byte) begin
                  error_count++;
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, want_byte, rsp_tdata);
               end
            end
         end
         if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rsp_idle_on && $urandom_range(99) < 35);
         end
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
